@@ src/scc_pkg.sv @@
package scc_pkg;

  localparam int SLOT_MAX = 6;

  // Scan codes (set 2, make codes)
  localparam logic [7:0] SC_FN        = 8'h02;
  localparam logic [7:0] SC_RECONNECT = 8'h2B;
  localparam logic [7:0] SC_POWER     = 8'h5D;
  localparam logic [7:0] SC_BATTERY   = 8'h64;
  localparam logic [7:0] SC_IDLE      = 8'h1B;
  localparam logic [7:0] SC_LCTRL     = 8'h14;
  localparam logic [7:0] SC_LSHIFT    = 8'h12;
  localparam logic [7:0] SC_LALT      = 8'h10;
  localparam logic [7:0] SC_LGUI      = 8'h07;
  localparam logic [7:0] SC_RSHIFT    = 8'h59;
  localparam logic [7:0] SC_RALT      = 8'h13;

  // Glyph indexes above the digits
  localparam logic [3:0] GLYPH_B = 4'd10;
  localparam logic [3:0] GLYPH_A = 4'd11;
  localparam logic [3:0] GLYPH_T = 4'd12;
  localparam logic [3:0] GLYPH_M = 4'd13;
  localparam logic [3:0] GLYPH_I = 4'd14;
  localparam logic [3:0] GLYPH_N = 4'd15;

  localparam logic [11:0] SHORT_IDLE_RESET     = 12'd300;
  localparam logic [11:0] LONG_IDLE_RESET      = 12'd1800;
  localparam logic [11:0] BATTERY_PERIOD_RESET = 12'd600;

  // digits 0..9, then B A T m i n
  localparam logic [7:0] GLYPH [16] = '{
    8'h27, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24,
    8'h25, 8'h26, 8'h05, 8'h04, 8'h17, 8'h10, 8'h0C, 8'h11
  };

  localparam logic [7:0] PLAIN_MAP [128] = '{
    8'h00, 8'h00, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00, 8'hE3,
    8'h29, 8'h00, 8'h00, 8'h00, 8'h00, 8'h2B, 8'h35, 8'h00,
    8'hE2, 8'h00, 8'hE1, 8'hE6, 8'hE0, 8'h14, 8'h1E, 8'h00,
    8'h00, 8'h00, 8'h1D, 8'h16, 8'h04, 8'h1A, 8'h1F, 8'h00,
    8'h00, 8'h06, 8'h1B, 8'h07, 8'h08, 8'h21, 8'h20, 8'h00,
    8'h52, 8'h00, 8'h19, 8'h09, 8'h17, 8'h15, 8'h22, 8'h4F,
    8'h00, 8'h11, 8'h05, 8'h0B, 8'h0A, 8'h1C, 8'h23, 8'h00,
    8'h00, 8'h00, 8'h10, 8'h0D, 8'h18, 8'h24, 8'h25, 8'h00,
    8'h00, 8'h36, 8'h0E, 8'h0C, 8'h12, 8'h27, 8'h26, 8'h00,
    8'h00, 8'h37, 8'h38, 8'h0F, 8'h33, 8'h13, 8'h2D, 8'h00,
    8'h00, 8'h00, 8'h34, 8'h00, 8'h2F, 8'h2E, 8'h00, 8'h00,
    8'h39, 8'hE5, 8'h28, 8'h30, 8'h2C, 8'h31, 8'h50, 8'h00,
    8'h51, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h4C, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h2A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam logic [7:0] FN_MAP [128] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h29, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h3A, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h3B, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h3D, 8'h3C, 8'h00,
    8'h4B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h3E, 8'h4D,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h3F, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h40, 8'h41, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h43, 8'h42, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h44, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h45, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h4A, 8'h00,
    8'h4E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef enum logic [1:0] {
    REG_SHORT_IDLE     = 2'd0,
    REG_LONG_IDLE      = 2'd1,
    REG_BATTERY_PERIOD = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_MOD_PRESS,
    CMD_MOD_RELEASE,
    CMD_FN_PRESS,
    CMD_RELEASE,
    CMD_KEY
  } cmd_kind_t;

  typedef enum logic [2:0] {
    FN_MAPPED,
    FN_RECONNECT,
    FN_POWER,
    FN_BATTERY,
    FN_IDLE
  } fn_kind_t;

  typedef struct packed {
    logic       action;
    logic [7:0] scan_byte;
    logic [6:0] battery_percent;
  } in_item_t;

  typedef struct packed {
    logic [7:0] modifier_bits;
    logic [7:0] key_slot_a;
    logic [7:0] key_slot_b;
    logic [7:0] key_slot_c;
    logic [7:0] key_slot_d;
    logic [7:0] key_slot_e;
    logic [7:0] key_slot_f;
    logic       report_valid;
    logic       power_off_request;
    logic       reconnect_request;
    logic       measure_request;
  } out_item_t;

  // Classified item handed from front to back
  typedef struct packed {
    cmd_kind_t  kind;
    fn_kind_t   fn_kind;
    logic       fn_release;
    logic [7:0] mod_mask;
    logic [7:0] plain_code;
    logic [7:0] fn_code;
    logic [7:0] digit_h;
    logic [7:0] digit_t;
    logic [7:0] digit_u;
  } cmd_t;

endpackage

@@ src/scc_fifo.sv @@
// Small flop queue; DEPTH must be a power of two, at least 2.
module scc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wdata;
  end

endmodule

@@ src/scc_front.sv @@
module scc_front (
  input  scc_pkg::in_item_t item,
  output scc_pkg::cmd_t     cmd
);
  import scc_pkg::*;

  function automatic logic [7:0] mod_mask_of(input logic [6:0] b);
    case ({1'b0, b})
      SC_LCTRL:  mod_mask_of = 8'h01;
      SC_LSHIFT: mod_mask_of = 8'h02;
      SC_LALT:   mod_mask_of = 8'h04;
      SC_LGUI:   mod_mask_of = 8'h08;
      SC_RSHIFT: mod_mask_of = 8'h20;
      SC_RALT:   mod_mask_of = 8'h40;
      default:   mod_mask_of = 8'h00;
    endcase
  endfunction

  logic [6:0]  base;
  logic        rel;
  logic [7:0]  mask;
  logic        hundreds;
  logic [6:0]  rem;
  logic [14:0] tens_prod;
  logic [3:0]  tens;
  logic [6:0]  tens_x10;
  logic [3:0]  units;

  assign base = item.scan_byte[6:0];
  assign rel  = item.scan_byte[7];
  assign mask = mod_mask_of(base);

  // Battery digits: pct <= 127, so hundreds is 0 or 1; tens by x205 >> 11
  assign hundreds  = (item.battery_percent >= 7'd100);
  assign rem       = hundreds ? item.battery_percent - 7'd100 : item.battery_percent;
  assign tens_prod = {8'd0, rem} * 15'd205;
  assign tens      = tens_prod[14:11];
  assign tens_x10  = {3'd0, tens} * 7'd10;
  assign units     = 4'(rem - tens_x10);

  always_comb begin
    cmd            = '0;
    cmd.kind       = CMD_KEY;
    cmd.fn_kind    = FN_MAPPED;
    cmd.mod_mask   = mask;
    cmd.plain_code = PLAIN_MAP[base];
    cmd.fn_code    = FN_MAP[base];
    cmd.digit_h    = GLYPH[{3'd0, hundreds}];
    cmd.digit_t    = GLYPH[tens];
    cmd.digit_u    = GLYPH[units];
    cmd.fn_release = ({1'b0, base} == SC_FN);
    if (item.action) begin
      cmd.kind = CMD_TICK;
    end else if (mask != 8'h00) begin
      cmd.kind = rel ? CMD_MOD_RELEASE : CMD_MOD_PRESS;
    end else if (item.scan_byte == SC_FN) begin
      cmd.kind = CMD_FN_PRESS;
    end else if (rel) begin
      cmd.kind = CMD_RELEASE;
    end else begin
      case ({1'b0, base})
        SC_RECONNECT: cmd.fn_kind = FN_RECONNECT;
        SC_POWER:     cmd.fn_kind = FN_POWER;
        SC_BATTERY:   cmd.fn_kind = FN_BATTERY;
        SC_IDLE:      cmd.fn_kind = FN_IDLE;
        default:      cmd.fn_kind = FN_MAPPED;
      endcase
    end
  end

endmodule

@@ src/scc_back.sv @@
module scc_back #(
  parameter int KEY_SLOTS = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  scc_pkg::cmd_t      cmd,
  input  logic               cmd_empty,
  output logic               cmd_pop,
  input  logic               res_full,
  output logic               res_push,
  output scc_pkg::out_item_t res,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_index,
  input  logic [11:0]        cfg_data
);
  import scc_pkg::*;

  logic [11:0] short_idle_seconds;
  logic [11:0] long_idle_seconds;
  logic [11:0] battery_period_seconds;

  logic [7:0]  modifier_state, modifier_state_next;
  logic [7:0]  key_slots [KEY_SLOTS];
  logic        fn_held, fn_held_next;
  logic        long_idle_mode, long_idle_mode_next;
  logic [11:0] idle_seconds, idle_seconds_next;
  logic [11:0] battery_seconds, battery_seconds_next;

  logic [7:0]  slot_cur  [SLOT_MAX];
  logic [7:0]  slot_next [SLOT_MAX];
  logic        go;
  logic [11:0] limit;
  logic [11:0] idle_inc;
  logic [11:0] batt_inc;
  logic        poff, recon, meas, valid;

  assign go       = !cmd_empty && !res_full;
  assign cmd_pop  = go;
  assign res_push = go;

  // Slots at or beyond KEY_SLOTS have no storage and read zero
  for (genvar g = 0; g < SLOT_MAX; g++) begin : g_view
    if (g < KEY_SLOTS) begin : g_real
      assign slot_cur[g] = key_slots[g];
    end else begin : g_none
      assign slot_cur[g] = 8'h00;
    end
  end

  assign limit    = long_idle_mode ? long_idle_seconds : short_idle_seconds;
  assign idle_inc = idle_seconds + 12'd1;
  assign batt_inc = battery_seconds + 12'd1;

  always_comb begin
    modifier_state_next  = modifier_state;
    fn_held_next         = fn_held;
    long_idle_mode_next  = long_idle_mode;
    idle_seconds_next    = idle_seconds;
    battery_seconds_next = battery_seconds;
    slot_next            = slot_cur;
    poff  = 1'b0;
    recon = 1'b0;
    meas  = 1'b0;
    valid = 1'b1;
    if (cmd.kind == CMD_TICK) begin
      valid                = 1'b0;
      idle_seconds_next    = idle_inc;
      battery_seconds_next = batt_inc;
      if (idle_inc >= limit) begin
        idle_seconds_next = '0;
        poff              = 1'b1;
      end
      if (batt_inc >= battery_period_seconds) begin
        battery_seconds_next = '0;
        meas                 = 1'b1;
      end
    end else begin
      idle_seconds_next = '0;
      case (cmd.kind)
        CMD_MOD_PRESS:   modifier_state_next = modifier_state | cmd.mod_mask;
        CMD_MOD_RELEASE: modifier_state_next = modifier_state & ~cmd.mod_mask;
        CMD_FN_PRESS: begin
          fn_held_next = 1'b1;
          slot_next[0] = 8'h00;
        end
        CMD_RELEASE: begin
          if (cmd.fn_release) fn_held_next = 1'b0;
          for (int i = 0; i < SLOT_MAX; i++) slot_next[i] = 8'h00;
        end
        CMD_KEY: begin
          if (!fn_held) begin
            slot_next[0] = cmd.plain_code;
          end else begin
            case (cmd.fn_kind)
              FN_RECONNECT: begin
                slot_next[0] = 8'h00;
                recon        = 1'b1;
              end
              FN_POWER: begin
                slot_next[0] = 8'h00;
                poff         = 1'b1;
              end
              FN_BATTERY: begin
                slot_next[0] = cmd.digit_h;
                slot_next[1] = cmd.digit_t;
                slot_next[2] = cmd.digit_u;
                slot_next[3] = GLYPH[GLYPH_B];
                slot_next[4] = GLYPH[GLYPH_A];
                slot_next[5] = GLYPH[GLYPH_T];
              end
              FN_IDLE: begin
                long_idle_mode_next = !long_idle_mode;
                slot_next[0] = long_idle_mode ? GLYPH[0] : GLYPH[3];
                slot_next[1] = long_idle_mode ? GLYPH[5] : GLYPH[0];
                slot_next[2] = GLYPH[GLYPH_M];
                slot_next[3] = GLYPH[GLYPH_I];
                slot_next[4] = GLYPH[GLYPH_N];
                slot_next[5] = 8'h00;
              end
              default: slot_next[0] = cmd.fn_code;
            endcase
          end
        end
        default: ;
      endcase
    end
    // Drop writes to slots that do not exist
    for (int i = 0; i < SLOT_MAX; i++) begin
      if (i >= KEY_SLOTS) slot_next[i] = 8'h00;
    end
  end

  always_comb begin
    res.modifier_bits     = modifier_state_next;
    res.key_slot_a        = slot_next[0];
    res.key_slot_b        = slot_next[1];
    res.key_slot_c        = slot_next[2];
    res.key_slot_d        = slot_next[3];
    res.key_slot_e        = slot_next[4];
    res.key_slot_f        = slot_next[5];
    res.report_valid      = valid;
    res.power_off_request = poff;
    res.reconnect_request = recon;
    res.measure_request   = meas;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      short_idle_seconds     <= SHORT_IDLE_RESET;
      long_idle_seconds      <= LONG_IDLE_RESET;
      battery_period_seconds <= BATTERY_PERIOD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SHORT_IDLE:     short_idle_seconds     <= cfg_data;
        REG_LONG_IDLE:      long_idle_seconds      <= cfg_data;
        REG_BATTERY_PERIOD: battery_period_seconds <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modifier_state  <= '0;
      fn_held         <= 1'b0;
      long_idle_mode  <= 1'b0;
      idle_seconds    <= '0;
      battery_seconds <= '0;
      for (int i = 0; i < KEY_SLOTS; i++) key_slots[i] <= 8'h00;
    end else if (go) begin
      modifier_state  <= modifier_state_next;
      fn_held         <= fn_held_next;
      long_idle_mode  <= long_idle_mode_next;
      idle_seconds    <= idle_seconds_next;
      battery_seconds <= battery_seconds_next;
      for (int i = 0; i < KEY_SLOTS; i++) key_slots[i] <= slot_next[i];
    end
  end

`ifndef NO_ASSERTIONS
  a_scan_clears_idle: assert property (@(posedge clk) disable iff (rst)
    (go && cmd.kind != CMD_TICK) |=> (idle_seconds == 12'd0))
    else $error("idle timer not cleared by scan byte");

  a_fn_press_holds: assert property (@(posedge clk) disable iff (rst)
    (go && cmd.kind == CMD_FN_PRESS) |=> fn_held)
    else $error("Fn press did not set fn_held");

  a_tick_keeps_mods: assert property (@(posedge clk) disable iff (rst)
    (go && cmd.kind == CMD_TICK) |=> $stable(modifier_state) && $stable(fn_held))
    else $error("tick changed key state");

  a_reconnect_is_report: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.reconnect_request) |-> (res.report_valid && fn_held))
    else $error("reconnect request outside an Fn chord");
`endif

endmodule

@@ src/scan_code_to_hid_report.sv @@
// Path: an item transferred into the command queue is applied by the back end,
//   and its result is pushed into the result queue (empty low) once that queue has room.
// Throughput: one item per cycle, in the back end too, while the result queue has room.
// Reset (rst, synchronous): both queues empty, report and timers zero,
//   Fn released, short idle mode, registers back to 300, 1800 and 600 s.
module scan_code_to_hid_report #(
  parameter int KEY_SLOTS = 6
) (
  input  logic               clk,
  input  logic               rst,
  // input queue side
  input  logic               push,
  input  scc_pkg::in_item_t  item,
  output logic               full,
  // result queue side
  input  logic               pop,
  output scc_pkg::out_item_t result,
  output logic               empty,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [11:0]        cfg_data
);
  import scc_pkg::*;

  cmd_t      cmd_in;
  cmd_t      cmd_out;
  logic      cmd_empty;
  logic      cmd_pop;
  out_item_t res;
  logic      res_push;
  logic      res_full;

  // Registers accept a write on any cycle.
  assign cfg_ready = 1'b1;

  // Front: decode the scan byte (modifier, Fn, release, chord) and look up
  // both key tables; Fn state lives in the back end, so both codes travel.
  scc_front u_front (
    .item (item),
    .cmd  (cmd_in)
  );

  // Two-entry queue between decode and execute; its full flag is the
  // input side's full.
  scc_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (2)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  // Back: report state, timers and config registers; one item per cycle
  // whenever the result queue has room.
  scc_back #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_out),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Result queue; the consumer may stall while new items keep arriving.
  scc_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule

@@ sim/tb_scan_code_to_hid_report.sv @@
`timescale 1ns / 100ps

module tb_scan_code_to_hid_report;
  import scc_pkg::*;

  localparam int         SLOTS          = SLOT_MAX;
  localparam logic       ACT_SCAN       = 1'b0;
  localparam logic       ACT_TICK       = 1'b1;
  localparam logic [7:0] KEY_RELEASE    = 8'h80;

  // HID modifier byte layout
  localparam logic [7:0] MOD_LCTRL      = 8'h01;
  localparam logic [7:0] MOD_LSHIFT     = 8'h02;
  localparam logic [7:0] MOD_LALT       = 8'h04;
  localparam logic [7:0] MOD_LGUI       = 8'h08;
  localparam logic [7:0] MOD_RSHIFT     = 8'h20;
  localparam logic [7:0] MOD_RALT       = 8'h40;

  localparam logic [7:0] MOD_CODES [6]  = '{SC_LCTRL, SC_LSHIFT, SC_LALT,
                                            SC_LGUI, SC_RSHIFT, SC_RALT};
  localparam logic [7:0] CHORD_CODES [4] = '{SC_RECONNECT, SC_POWER,
                                             SC_BATTERY, SC_IDLE};

  localparam int HOLDOFF_CYCLES = 250;     // result side held off this long once
  localparam int CYCLE_LIMIT    = 100000;  // watchdog, far above a slow clean run
  localparam int DISPLAY_LIMIT  = 10;      // only the first mismatches are printed
  localparam int TOTAL_ITEMS    = 1450;

  // DUT ports; every input starts at a known value
  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        push      = 1'b0;
  in_item_t    item      = '0;
  logic        full;
  logic        pop       = 1'b0;
  out_item_t   result;
  logic        empty;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [11:0] cfg_data  = '0;

  // Keyboard state as the testbench sees it
  logic [7:0]  held_mods;
  logic [7:0]  report_keys [SLOTS];
  logic        fn_down;
  logic        long_idle;
  logic [11:0] idle_secs;
  logic [11:0] battery_secs;
  logic [11:0] short_idle_limit;
  logic [11:0] long_idle_limit;
  logic [11:0] battery_period;

  out_item_t   expected_reports [$];
  int unsigned accepted_items = 0;
  int unsigned report_errors  = 0;
  int unsigned cycle_count    = 0;

  // Pacing knobs: written with <= (by the stimulus or the pop driver), read at the falling edge
  bit          sender_pacing  = 1'b1;
  bit          reader_pacing  = 1'b1;
  int unsigned holdoffs_asked = 0;
  int unsigned holdoffs_done  = 0;
  int          holdoff_left   = 0;

  scan_code_to_hid_report #(
    .KEY_SLOTS (SLOTS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .full      (full),
    .pop       (pop),
    .result    (result),
    .empty     (empty),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("scan_code_to_hid_report: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Report predictor: advances the keyboard state by one item and returns the
  // report the block should produce for it.
  // ---------------------------------------------------------------------------
  function automatic out_item_t next_report(input in_item_t it);
    out_item_t   r;
    logic [6:0]  base;
    logic [7:0]  mod_mask;
    logic [11:0] idle_limit;
    int          pct;
    r    = '0;
    base = it.scan_byte[6:0];
    pct  = int'(it.battery_percent);
    if (it.action == ACT_TICK) begin
      // one second: both timers advance, 12-bit wrap
      idle_limit   = long_idle ? long_idle_limit : short_idle_limit;
      idle_secs    = idle_secs + 12'd1;
      battery_secs = battery_secs + 12'd1;
      if (idle_secs >= idle_limit) begin
        idle_secs           = '0;
        r.power_off_request = 1'b1;
      end
      if (battery_secs >= battery_period) begin
        battery_secs      = '0;
        r.measure_request = 1'b1;
      end
    end else begin
      r.report_valid = 1'b1;
      idle_secs      = '0;
      // modifier match ignores the release bit
      case ({1'b0, base})
        SC_LCTRL:  mod_mask = MOD_LCTRL;
        SC_LSHIFT: mod_mask = MOD_LSHIFT;
        SC_LALT:   mod_mask = MOD_LALT;
        SC_LGUI:   mod_mask = MOD_LGUI;
        SC_RSHIFT: mod_mask = MOD_RSHIFT;
        SC_RALT:   mod_mask = MOD_RALT;
        default:   mod_mask = '0;
      endcase
      if (mod_mask != '0) begin
        if (it.scan_byte[7]) held_mods &= ~mod_mask;
        else                 held_mods |= mod_mask;
      end else if (it.scan_byte == SC_FN) begin
        fn_down        = 1'b1;
        report_keys[0] = '0;
      end else if (it.scan_byte[7]) begin
        // any release empties the key slots; Fn release also drops Fn
        if ({1'b0, base} == SC_FN) fn_down = 1'b0;
        foreach (report_keys[i]) report_keys[i] = '0;
      end else if (!fn_down) begin
        report_keys[0] = PLAIN_MAP[base];
      end else begin
        case (it.scan_byte)
          SC_RECONNECT: begin
            report_keys[0]      = '0;
            r.reconnect_request = 1'b1;
          end
          SC_POWER: begin
            report_keys[0]      = '0;
            r.power_off_request = 1'b1;
          end
          SC_BATTERY: begin
            // hundreds, tens, units, then B A T
            report_keys[0] = GLYPH[(pct / 100) % 10];
            report_keys[1] = GLYPH[(pct % 100) / 10];
            report_keys[2] = GLYPH[pct % 10];
            report_keys[3] = GLYPH[GLYPH_B];
            report_keys[4] = GLYPH[GLYPH_A];
            report_keys[5] = GLYPH[GLYPH_T];
          end
          SC_IDLE: begin
            // spells "30min" going long, "05min" going short
            if (!long_idle) begin
              long_idle      = 1'b1;
              report_keys[0] = GLYPH[3];
              report_keys[1] = GLYPH[0];
            end else begin
              long_idle      = 1'b0;
              report_keys[0] = GLYPH[0];
              report_keys[1] = GLYPH[5];
            end
            report_keys[2] = GLYPH[GLYPH_M];
            report_keys[3] = GLYPH[GLYPH_I];
            report_keys[4] = GLYPH[GLYPH_N];
            report_keys[5] = '0;
          end
          default: report_keys[0] = FN_MAP[base];
        endcase
      end
    end
    r.modifier_bits = held_mods;
    r.key_slot_a    = report_keys[0];
    r.key_slot_b    = report_keys[1];
    r.key_slot_c    = report_keys[2];
    r.key_slot_d    = report_keys[3];
    r.key_slot_e    = report_keys[4];
    r.key_slot_f    = report_keys[5];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: pop pacing with an occasional long hold-off, and the checker.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : pop_driver
    if (rst) begin
      pop <= 1'b0;
    end else if (holdoff_left != 0) begin
      pop          <= 1'b0;
      holdoff_left <= holdoff_left - 1;
    end else if (holdoffs_done != holdoffs_asked) begin
      holdoffs_done <= holdoffs_done + 1;
      holdoff_left  <= HOLDOFF_CYCLES - 1;
      pop           <= 1'b0;
    end else begin
      pop <= !(reader_pacing && ($urandom_range(99) < 9));
    end
  end

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      report_errors++;
      if (report_errors <= DISPLAY_LIMIT)
        $display("%0t: %s expected %h, got %h", $realtime, name, want, got);
    end
  endfunction

  // Outputs sampled at the rising edge, before the block updates them
  always @(posedge clk) begin : result_checker
    out_item_t want;
    if (!rst && pop && !empty) begin
      if (expected_reports.size() == 0) begin
        report_errors++;
        if (report_errors <= DISPLAY_LIMIT)
          $display("%0t: report %h with nothing expected", $realtime, result);
      end else begin
        want = expected_reports.pop_front();
        check_field("modifier_bits",     want.modifier_bits,     result.modifier_bits);
        check_field("key_slot_a",        want.key_slot_a,        result.key_slot_a);
        check_field("key_slot_b",        want.key_slot_b,        result.key_slot_b);
        check_field("key_slot_c",        want.key_slot_c,        result.key_slot_c);
        check_field("key_slot_d",        want.key_slot_d,        result.key_slot_d);
        check_field("key_slot_e",        want.key_slot_e,        result.key_slot_e);
        check_field("key_slot_f",        want.key_slot_f,        result.key_slot_f);
        check_field("report_valid", 8'(want.report_valid),
                    8'(result.report_valid));
        check_field("power_off_request", 8'(want.power_off_request),
                    8'(result.power_off_request));
        check_field("reconnect_request", 8'(want.reconnect_request),
                    8'(result.reconnect_request));
        check_field("measure_request", 8'(want.measure_request),
                    8'(result.measure_request));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side. All stimulus tasks start and end at a falling edge. push stays
  // high between back-to-back transfers; only idling or draining lowers it.
  // ---------------------------------------------------------------------------
  function automatic in_item_t scan_item(input logic [7:0] code);
    in_item_t it;
    it.action          = ACT_SCAN;
    it.scan_byte       = code;
    it.battery_percent = 7'($urandom_range(100));
    return it;
  endfunction

  // scan byte and percent are don't-care on a tick, so they get noise
  function automatic in_item_t tick_item();
    in_item_t it;
    it.action          = ACT_TICK;
    it.scan_byte       = 8'($urandom_range(255));
    it.battery_percent = 7'($urandom_range(100));
    return it;
  endfunction

  task automatic send_keystroke(input in_item_t it);
    while (sender_pacing && ($urandom_range(99) < 9)) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    // transfer happened at this edge
    expected_reports.push_back(next_report(it));
    accepted_items++;
    @(negedge clk);
  endtask

  // Sender pause: nothing offered until every report is back and the block
  // has settled.
  task automatic wait_for_reports();
    push <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(input cfg_reg_t idx, input logic [11:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SHORT_IDLE:     short_idle_limit = value;
      REG_LONG_IDLE:      long_idle_limit  = value;
      REG_BATTERY_PERIOD: battery_period   = value;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_limits(input logic [11:0] short_s, input logic [11:0] long_s,
                            input logic [11:0] period_s);
    wait_for_reports();
    write_register(REG_SHORT_IDLE, short_s);
    write_register(REG_LONG_IDLE, long_s);
    write_register(REG_BATTERY_PERIOD, period_s);
    cfg_valid <= 1'b0;
  endtask

  // One burst of keyboard activity; mostly well-formed, some noise
  task automatic send_random_sequence();
    logic [7:0] key;
    logic [7:0] mod;
    bit         shifted;
    int         n;
    key     = 8'($urandom_range(127));
    mod     = MOD_CODES[$urandom_range(5)];
    shifted = 1'($urandom_range(1));
    n       = $urandom_range(1, 4);
    case ($urandom_range(9))
      0, 1, 2: begin
        // plain keystroke, sometimes under a modifier
        if (shifted) send_keystroke(scan_item(mod));
        send_keystroke(scan_item(key));
        send_keystroke(scan_item(key | KEY_RELEASE));
        if (shifted) send_keystroke(scan_item(mod | KEY_RELEASE));
      end
      3, 4: begin
        // Fn held across a few chord keys or Fn-layer keys
        send_keystroke(scan_item(SC_FN));
        repeat (n) begin
          key = ($urandom_range(4) == 0) ? 8'($urandom_range(127))
                                         : CHORD_CODES[$urandom_range(3)];
          send_keystroke(scan_item(key));
          if ($urandom_range(2) == 0) send_keystroke(scan_item(key | KEY_RELEASE));
        end
        send_keystroke(scan_item(SC_FN | KEY_RELEASE));
      end
      5, 6: repeat ($urandom_range(1, 12)) send_keystroke(tick_item());
      7: send_keystroke(scan_item(mod | (shifted ? KEY_RELEASE : 8'h00)));
      default: begin
        // noise: any byte, including stray Fn or releases, mixed with ticks
        repeat (n) begin
          if ($urandom_range(3) == 0) send_keystroke(tick_item());
          else send_keystroke(scan_item(8'($urandom_range(255))));
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_key_map_directed();
    in_item_t it;
    send_keystroke(tick_item());
    foreach (MOD_CODES[i]) send_keystroke(scan_item(MOD_CODES[i]));
    send_keystroke(scan_item(SC_LSHIFT | KEY_RELEASE));
    send_keystroke(scan_item(8'h00));
    send_keystroke(scan_item(8'h71));
    send_keystroke(scan_item(8'h7F));
    send_keystroke(scan_item(8'hFF));
    send_keystroke(scan_item(SC_FN));
    send_keystroke(scan_item(8'h0E));       // Fn-layer key
    send_keystroke(scan_item(SC_RECONNECT));
    send_keystroke(scan_item(SC_POWER));
    // battery spelled at the low end, at 100, and past 100
    it = scan_item(SC_BATTERY);
    it.battery_percent = 7'd0;
    send_keystroke(it);
    it.battery_percent = 7'd100;
    send_keystroke(it);
    it.battery_percent = 7'd127;
    send_keystroke(it);
    send_keystroke(scan_item(SC_IDLE));     // to long
    send_keystroke(scan_item(SC_IDLE));     // back to short
    send_keystroke(scan_item(SC_FN | KEY_RELEASE));
    send_keystroke(scan_item(SC_POWER));    // Fn up: plain table
    send_keystroke(scan_item(KEY_RELEASE));
    send_keystroke(tick_item());
  endtask

  // Several register settings, extremes included; small limits so the
  // power-off and measure requests fire often.
  task automatic test_limit_settings();
    int unsigned start;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       set_limits(12'd1, 12'd1, 12'd1);
        1:       set_limits(12'd4095, 12'd4095, 12'd4095);
        2:       set_limits(12'd2, 12'd5, 12'd3);
        3:       set_limits(12'd4095, 12'd1, 12'd2);
        default: set_limits(12'($urandom_range(1, 16)), 12'($urandom_range(1, 16)),
                            12'($urandom_range(1, 16)));
      endcase
      start = accepted_items;
      while (accepted_items - start < 80) send_random_sequence();
    end
    set_limits(12'($urandom_range(1, 40)), 12'($urandom_range(1, 40)),
               12'($urandom_range(1, 40)));
  endtask

  // Result side held off while items keep coming: block fills and stalls push
  task automatic test_full_stall();
    int unsigned start;
    sender_pacing  <= 1'b0;
    holdoffs_asked <= holdoffs_asked + 1;
    start = accepted_items;
    while (accepted_items - start < 60) send_random_sequence();
    sender_pacing <= 1'b1;
    wait_for_reports();
  endtask

  task automatic test_unpaced_stretch();
    int unsigned start;
    sender_pacing <= 1'b0;
    reader_pacing <= 1'b0;
    start = accepted_items;
    while (accepted_items - start < 200) send_random_sequence();
    sender_pacing <= 1'b1;
    reader_pacing <= 1'b1;
  endtask

  task automatic test_typing_random();
    while (accepted_items < TOTAL_ITEMS) send_random_sequence();
  endtask

  initial begin
    held_mods        = '0;
    foreach (report_keys[i]) report_keys[i] = '0;
    fn_down          = 1'b0;
    long_idle        = 1'b0;
    idle_secs        = '0;
    battery_secs     = '0;
    short_idle_limit = SHORT_IDLE_RESET;
    long_idle_limit  = LONG_IDLE_RESET;
    battery_period   = BATTERY_PERIOD_RESET;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_key_map_directed();
    test_limit_settings();
    test_full_stall();
    test_unpaced_stretch();
    test_typing_random();

    // drain and let the pipeline settle; the watchdog bounds this
    wait_for_reports();
    repeat (5) @(posedge clk);

    if (report_errors == 0)
      $display("scan_code_to_hid_report: match");
    else
      $display("scan_code_to_hid_report: mismatch");
    $finish;
  end

endmodule

@@ sim.f @@
src/scc_pkg.sv
src/scc_fifo.sv
src/scc_front.sv
src/scc_back.sv
src/scan_code_to_hid_report.sv
sim/tb_scan_code_to_hid_report.sv
